// ----- hw/rtl/sasr_pkg.sv -----
package sasr_pkg;

    localparam int unsigned CHANNELS_DEFAULT = 22;
    localparam logic [7:0]  ANGLE_MAX        = 8'd180;

    localparam logic [7:0]  PPD_RESET        = 8'd20;
    localparam logic [15:0] PAZ_RESET        = 16'd900;

    localparam int unsigned CFG_IDX_W        = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_PER_DEGREE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_AT_ZERO    = 4'd1;

    typedef enum logic [1:0] {
        ACT_MOVE   = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_LIMITS = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef struct packed {
        t_action    action;
        logic [4:0] channel;
        logic [7:0] target_angle;
        logic       from_zero;
        logic [7:0] low_limit;
        logic [7:0] high_limit;
    } t_sasr_in;

    typedef struct packed {
        logic [4:0]  out_channel;
        logic [7:0]  out_angle;
        logic [15:0] compare_value;
        logic        last;
    } t_sasr_out;

    typedef struct packed {
        logic       start;
        logic [7:0] angle;
        logic [7:0] gain;
        logic [15:0] offset;
    } t_sasr_mul_req;

endpackage

// ----- hw/rtl/sasr_cmp_unit.sv -----
module sasr_cmp_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sasr_pkg::t_sasr_mul_req i_req,
    output logic                   o_done,
    output logic [15:0]            o_value
);
    import sasr_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [2:0]  r_cnt;
    logic [16:0] r_acc;
    logic [14:0] r_mcand;
    logic [7:0]  r_mplier;
    logic [15:0] r_value;
    logic [16:0] n_acc;

    // one shift-add step per cycle, offset preloaded into the accumulator
    always_comb begin
        n_acc = r_acc;
        if (r_mplier[0]) begin
            n_acc = r_acc + {2'b00, r_mcand};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc    <= {1'b0, i_req.offset};
            r_mcand  <= {7'b0, i_req.angle};
            r_mplier <= i_req.gain;
        end else if (r_busy) begin
            r_acc    <= n_acc;
            r_mcand  <= {r_mcand[13:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[7:1]};
            if (r_cnt == 3'd7) begin
                // saturate to the timer width
                r_value <= n_acc[16] ? 16'hFFFF : n_acc[15:0];
            end
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;

endmodule

// ----- hw/rtl/servo_angle_slew_ramp.sv -----
// Result path: a command that yields a result passes ST_EVAL, then ST_MUL while the
//   eight-step shift-add unit forms the compare value; o_result and o_strobe are registered.
// busy is high in ST_EVAL and ST_MUL, so no new command is taken until that unit is
//   done; a command with no result goes back to idle after ST_EVAL.
// Reset (synchronous, active low) restores all angles to 0 and limits to 0..180.
// The receiver cannot stall: o_strobe is high for exactly one cycle per result.
module servo_angle_slew_ramp #(
    parameter int unsigned CHANNELS = sasr_pkg::CHANNELS_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  sasr_pkg::t_sasr_in                 i_cmd,
    output logic                               o_strobe,
    output sasr_pkg::t_sasr_out                o_result,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sasr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [15:0]                        i_cfg_data
);
    import sasr_pkg::*;

    localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EVAL = 3'b010,
        ST_MUL  = 3'b100
    } t_state;

    t_state      r_state, n_state;
    t_sasr_in    r_in;
    logic [7:0]  r_ppd;
    logic [15:0] r_paz;
    logic [7:0]  r_angle_now [CHANNELS];
    logic [7:0]  r_lim_lo    [CHANNELS];
    logic [7:0]  r_lim_hi    [CHANNELS];
    logic        r_ramping, n_ramping;
    logic [4:0]  r_active, n_active;
    logic [7:0]  r_goal, n_goal;
    logic [4:0]  r_res_ch, n_res_ch;
    logic [7:0]  r_res_ang, n_res_ang;
    logic        r_res_last, n_res_last;
    logic        r_strobe;
    t_sasr_out   r_out;

    logic        ch_ok;
    logic [IDX_W-1:0] rd_idx, wr_idx;
    logic [7:0]  cur, goal_sel, step;
    logic        ang_we, lim_we;
    logic [7:0]  ang_wval;
    logic        mul_start;
    logic        mul_done;
    logic [15:0] mul_value;
    t_sasr_mul_req mul_req;

    assign ch_ok    = {1'b0, r_in.channel} < 6'(CHANNELS);
    assign rd_idx   = (r_in.action == ACT_TICK) ? r_active[IDX_W-1:0]
                                                : r_in.channel[IDX_W-1:0];
    assign goal_sel = (r_in.action == ACT_TICK) ? r_goal : r_in.target_angle;
    assign cur      = r_angle_now[rd_idx];

    // advance one degree toward the goal
    always_comb begin
        if (cur < goal_sel) begin
            step = cur + 8'd1;
        end else if (cur > goal_sel) begin
            step = cur - 8'd1;
        end else begin
            step = cur;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ramping  = r_ramping;
        n_active   = r_active;
        n_goal     = r_goal;
        n_res_ch   = r_res_ch;
        n_res_ang  = r_res_ang;
        n_res_last = r_res_last;
        ang_we     = 1'b0;
        ang_wval   = step;
        wr_idx     = rd_idx;
        lim_we     = 1'b0;
        mul_start  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = ST_IDLE;
                unique case (r_in.action)
                    ACT_TICK: begin
                        if (r_ramping) begin
                            ang_we     = 1'b1;
                            n_res_ch   = r_active;
                            n_res_ang  = step;
                            n_res_last = (step == r_goal);
                            if (step == r_goal) begin
                                n_ramping = 1'b0;
                            end
                            mul_start = 1'b1;
                            n_state   = ST_MUL;
                        end
                    end
                    ACT_LIMITS: begin
                        lim_we = ch_ok;
                    end
                    ACT_MOVE: begin
                        if (!r_ramping && ch_ok
                            && !(r_in.target_angle < r_lim_lo[rd_idx])
                            && !(r_in.target_angle > r_lim_hi[rd_idx])) begin
                            ang_we    = 1'b1;
                            n_res_ch  = r_in.channel;
                            mul_start = 1'b1;
                            n_state   = ST_MUL;
                            if (r_in.from_zero || cur == r_in.target_angle) begin
                                ang_wval   = r_in.target_angle;
                                n_res_ang  = r_in.target_angle;
                                n_res_last = 1'b1;
                            end else begin
                                n_active   = r_in.channel;
                                n_goal     = r_in.target_angle;
                                n_ramping  = (step != r_in.target_angle);
                                n_res_ang  = step;
                                n_res_last = (step == r_in.target_angle);
                            end
                        end
                    end
                    ACT_NONE: begin
                        n_state = ST_IDLE;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_MUL: begin
                if (mul_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign mul_req.start  = mul_start;
    assign mul_req.angle  = n_res_ang;
    assign mul_req.gain   = r_ppd;
    assign mul_req.offset = r_paz;

    sasr_cmp_unit u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_value (mul_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ramping <= 1'b0;
            r_active  <= '0;
            r_goal    <= '0;
            r_strobe  <= 1'b0;
            r_ppd     <= PPD_RESET;
            r_paz     <= PAZ_RESET;
            for (int i = 0; i < int'(CHANNELS); i++) begin
                r_angle_now[i] <= '0;
                r_lim_lo[i]    <= '0;
                r_lim_hi[i]    <= ANGLE_MAX;
            end
        end else begin
            r_state   <= n_state;
            r_ramping <= n_ramping;
            r_active  <= n_active;
            r_goal    <= n_goal;
            r_strobe  <= (r_state == ST_MUL) && mul_done;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_PULSE_PER_DEGREE: r_ppd <= i_cfg_data[7:0];
                    CFG_PULSE_AT_ZERO:    r_paz <= i_cfg_data;
                    default: ;
                endcase
            end
            if (ang_we) begin
                r_angle_now[wr_idx] <= ang_wval;
            end
            if (lim_we) begin
                r_lim_lo[wr_idx] <= r_in.low_limit;
                r_lim_hi[wr_idx] <= r_in.high_limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_cmd;
        end
        r_res_ch   <= n_res_ch;
        r_res_ang  <= n_res_ang;
        r_res_last <= n_res_last;
        if ((r_state == ST_MUL) && mul_done) begin
            r_out.out_channel   <= r_res_ch;
            r_out.out_angle     <= r_res_ang;
            r_out.compare_value <= (r_res_ang > ANGLE_MAX) ? 16'd0 : mul_value;
            r_out.last          <= r_res_last;
        end
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_strobe    = r_strobe;
    assign o_result    = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- verif/servo_angle_slew_ramp_tb.sv -----
`timescale 1ns / 1ps

module servo_angle_slew_ramp_tb;
    import sasr_pkg::*;

    localparam int NCH = CHANNELS_DEFAULT;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_sasr_in             i_cmd;
    logic                 o_strobe;
    t_sasr_out            o_result;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;

    // shadow copy of the block state
    logic [7:0]  angle_q [NCH];
    logic [7:0]  lim_lo  [NCH];
    logic [7:0]  lim_hi  [NCH];
    logic        ramp_on;
    logic [4:0]  ramp_ch;
    logic [7:0]  ramp_goal;
    logic [7:0]  ppd;
    logic [15:0] paz;

    t_sasr_out due_steps[$];
    int        err_cnt;
    int        work_cnt;
    bit        quiet;

    servo_angle_slew_ramp uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [15:0] compare_for(input logic [7:0] a);
        logic [23:0] v;
        if (a > ANGLE_MAX)
            return 16'd0;
        v = 24'(a) * 24'(ppd) + 24'(paz);
        return (v > 24'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic t_sasr_out step_out(input logic [4:0] ch, input logic [7:0] a,
                                           input logic done);
        t_sasr_out r;
        r.out_channel   = ch;
        r.out_angle     = a;
        r.compare_value = compare_for(a);
        r.last          = done;
        return r;
    endfunction

    // advance the running ramp by one degree
    function automatic t_sasr_out ramp_advance();
        logic [7:0] a;
        a = angle_q[ramp_ch];
        if (a < ramp_goal)
            a = a + 8'd1;
        else if (a > ramp_goal)
            a = a - 8'd1;
        angle_q[ramp_ch] = a;
        if (a == ramp_goal)
            ramp_on = 1'b0;
        return step_out(ramp_ch, a, a == ramp_goal);
    endfunction

    function automatic bit servo_next(input t_sasr_in c, output t_sasr_out r);
        r = '0;
        case (c.action)
            ACT_TICK: begin
                if (!ramp_on)
                    return 1'b0;
                r = ramp_advance();
                return 1'b1;
            end
            ACT_LIMITS: begin
                if (c.channel < NCH) begin
                    lim_lo[c.channel] = c.low_limit;
                    lim_hi[c.channel] = c.high_limit;
                end
                return 1'b0;
            end
            ACT_MOVE: begin
                if (ramp_on || c.channel >= NCH)
                    return 1'b0;
                if (c.target_angle < lim_lo[c.channel] ||
                    c.target_angle > lim_hi[c.channel])
                    return 1'b0;
                if (c.from_zero || angle_q[c.channel] == c.target_angle) begin
                    angle_q[c.channel] = c.target_angle;
                    r = step_out(c.channel, c.target_angle, 1'b1);
                    return 1'b1;
                end
                ramp_ch   = c.channel;
                ramp_goal = c.target_angle;
                ramp_on   = 1'b1;
                r = ramp_advance();
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_sasr_in mk_cmd(input t_action act, input int ch, input int tgt,
                                        input bit fz, input int lo, input int hi);
        t_sasr_in c;
        c.action       = act;
        c.channel      = 5'(ch);
        c.target_angle = 8'(tgt);
        c.from_zero    = fz;
        c.low_limit    = 8'(lo);
        c.high_limit   = 8'(hi);
        return c;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // hold the command until the block takes it, then predict its step
    task automatic send_cmd(input t_sasr_in c);
        t_sasr_out r;
        int        n;
        n = quiet ? 0 : gap_len();
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        if (servo_next(c, r))
            due_steps.push_back(r);
        work_cnt++;
    endtask

    task automatic settle();
        start <= 1'b0;
        while (due_steps.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_PULSE_PER_DEGREE)
            ppd = data[7:0];
        else if (idx == CFG_PULSE_AT_ZERO)
            paz = data;
        @(posedge i_clk);
    endtask

    task automatic load_limits(input int ch);
        int m, lo, hi;
        m = $urandom_range(0, 9);
        if (m < 6) begin
            lo = $urandom_range(0, 180);
            hi = $urandom_range(lo, 180);
        end else if (m < 8) begin
            lo = $urandom_range(1, 255);
            hi = $urandom_range(0, lo - 1);
        end else begin
            lo = $urandom_range(0, 100);
            hi = $urandom_range(150, 255);
        end
        send_cmd(mk_cmd(ACT_LIMITS, ch, $urandom_range(0, 255), $urandom_range(0, 1), lo, hi));
    endtask

    // one move, then ticks until the ramp ends, with stray transactions mixed in
    task automatic move_episode(input int ch);
        int t, m;
        m = $urandom_range(0, 9);
        if (m < 9) begin
            t = int'(angle_q[ch]) + $urandom_range(0, 16) - 8;
            if (t < 0) t = 0;
            if (t > 255) t = 255;
            if (lim_lo[ch] <= lim_hi[ch] && $urandom_range(0, 4) != 0) begin
                if (t < lim_lo[ch]) t = lim_lo[ch];
                if (t > lim_hi[ch]) t = lim_hi[ch];
            end
        end else begin
            t = $urandom_range(0, 255);
        end
        send_cmd(mk_cmd(ACT_MOVE, ch, t, $urandom_range(0, 6) == 0,
                        $urandom_range(0, 255), $urandom_range(0, 255)));
        while (ramp_on) begin
            if ($urandom_range(0, 9) == 0)
                send_cmd(t_sasr_in'($urandom));
            else
                send_cmd(mk_cmd(ACT_TICK, $urandom_range(0, 31), $urandom_range(0, 255),
                                $urandom_range(0, 1), $urandom_range(0, 255),
                                $urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0)
            send_cmd(mk_cmd(ACT_TICK, ch, t, 1'b0, 0, 0));
    endtask

    task automatic run_random(input int amount);
        int stop_at, pick, ch;
        stop_at = work_cnt + amount;
        while (work_cnt < stop_at) begin
            quiet = ($urandom_range(0, 4) == 0);
            pick  = $urandom_range(0, 99);
            ch    = $urandom_range(0, NCH - 1);
            if (pick < 8)
                send_cmd(t_sasr_in'($urandom));
            else if (pick < 20)
                load_limits(ch);
            else
                move_episode(ch);
        end
        quiet = 1'b0;
    endtask

    task automatic test_move_basics();
        send_cmd(mk_cmd(ACT_MOVE, 0, 0, 1'b0, 0, 0));          // already there
        send_cmd(mk_cmd(ACT_MOVE, NCH - 1, 180, 1'b1, 0, 0));  // jump to the top
        send_cmd(mk_cmd(ACT_MOVE, NCH - 1, 178, 1'b0, 0, 0));  // ramp starts
        send_cmd(mk_cmd(ACT_MOVE, NCH - 1, 0, 1'b1, 0, 0));    // dropped while ramping
        send_cmd(mk_cmd(ACT_TICK, 0, 0, 1'b0, 0, 0));
        send_cmd(mk_cmd(ACT_TICK, 0, 0, 1'b0, 0, 0));          // nothing to ramp
    endtask

    task automatic test_limit_window();
        send_cmd(mk_cmd(ACT_LIMITS, 5, 0, 1'b0, 10, 20));
        send_cmd(mk_cmd(ACT_MOVE, 5, 9, 1'b1, 0, 0));
        send_cmd(mk_cmd(ACT_MOVE, 5, 21, 1'b0, 0, 0));
        send_cmd(mk_cmd(ACT_MOVE, 5, 20, 1'b1, 0, 0));
        send_cmd(mk_cmd(ACT_MOVE, 5, 18, 1'b0, 0, 0));
        send_cmd(mk_cmd(ACT_LIMITS, 5, 0, 1'b0, 0, 180));      // ramp keeps going
        send_cmd(mk_cmd(ACT_TICK, 5, 0, 1'b0, 0, 0));
        send_cmd(mk_cmd(ACT_LIMITS, 6, 0, 1'b0, 50, 40));      // empty window
        send_cmd(mk_cmd(ACT_MOVE, 6, 45, 1'b1, 0, 0));
    endtask

    task automatic test_ignored_cmds();
        send_cmd(mk_cmd(ACT_LIMITS, NCH, 0, 1'b1, 255, 255));
        send_cmd(mk_cmd(ACT_MOVE, 31, 5, 1'b1, 0, 0));
        send_cmd(mk_cmd(ACT_NONE, 31, 255, 1'b1, 255, 255));
    endtask

    task automatic test_wide_angles();
        send_cmd(mk_cmd(ACT_LIMITS, 3, 0, 1'b0, 0, 255));
        send_cmd(mk_cmd(ACT_MOVE, 3, 255, 1'b1, 0, 0));
        send_cmd(mk_cmd(ACT_MOVE, 3, 254, 1'b0, 0, 0));
        send_cmd(mk_cmd(ACT_MOVE, 3, 181, 1'b1, 0, 0));
        send_cmd(mk_cmd(ACT_MOVE, 3, 180, 1'b0, 0, 0));
    endtask

    task automatic test_config_sweep();
        logic [15:0] ppd_set [6];
        logic [15:0] paz_set [6];
        ppd_set = '{16'hFFFF, 16'h0000, 16'h00FF, 16'hFF00, 16'h0000, 16'h0000};
        paz_set = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000};
        ppd_set[4] = 16'($urandom);
        paz_set[4] = 16'($urandom);
        ppd_set[5] = 16'($urandom_range(0, 65535));
        paz_set[5] = 16'($urandom_range(0, 20000));
        for (int i = 0; i < 6; i++) begin
            settle();
            write_reg(CFG_PULSE_PER_DEGREE, ppd_set[i]);
            write_reg(CFG_PULSE_AT_ZERO, paz_set[i]);
            run_random(180);
        end
    endtask

    always @(posedge i_clk) begin
        t_sasr_out want;
        if (i_rst_n && o_strobe) begin
            if (due_steps.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result, expected none, ", $time,
                         "actual ch=%0d angle=%0d cmp=%0d last=%0b",
                         o_result.out_channel, o_result.out_angle,
                         o_result.compare_value, o_result.last);
            end else begin
                want = due_steps.pop_front();
                if (o_result.out_channel !== want.out_channel ||
                    o_result.out_angle !== want.out_angle ||
                    o_result.compare_value !== want.compare_value ||
                    o_result.last !== want.last) begin
                    err_cnt++;
                    $display("%0t: mismatch, expected ch=%0d angle=%0d cmp=%0d last=%0b, ",
                             $time, want.out_channel, want.out_angle, want.compare_value,
                             want.last,
                             "actual ch=%0d angle=%0d cmp=%0d last=%0b",
                             o_result.out_channel, o_result.out_angle,
                             o_result.compare_value, o_result.last);
                end
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        err_cnt     = 0;
        work_cnt    = 0;
        quiet       = 1'b0;
        ppd         = PPD_RESET;
        paz         = PAZ_RESET;
        ramp_on     = 1'b0;
        ramp_ch     = '0;
        ramp_goal   = '0;
        for (int i = 0; i < NCH; i++) begin
            angle_q[i] = 8'd0;
            lim_lo[i]  = 8'd0;
            lim_hi[i]  = ANGLE_MAX;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_move_basics();
        test_limit_window();
        test_ignored_cmds();
        test_wide_angles();
        run_random(370);
        test_config_sweep();

        settle();
        if (err_cnt == 0)
            $display("servo_angle_slew_ramp_tb: PASS");
        else
            $display("servo_angle_slew_ramp_tb: FAIL");
        $finish;
    end

    initial begin
        #10ms;
        $display("servo_angle_slew_ramp_tb: FAIL");
        $finish;
    end

endmodule

// ----- servo_angle_slew_ramp.f -----
hw/rtl/sasr_pkg.sv
hw/rtl/sasr_cmp_unit.sv
hw/rtl/servo_angle_slew_ramp.sv
verif/servo_angle_slew_ramp_tb.sv
